/* rtl/core/deba_pkg.sv */
// Shared types and constants for the double-ended bump allocator.
package deba_pkg;

    typedef enum logic [1:0] {
        MODE_ALLOC     = 2'd0,
        MODE_FREE_ALL  = 2'd1,
        MODE_FREE_TAIL = 2'd2,
        MODE_CHECK     = 2'd3
    } mode_t;

    localparam logic CFG_REGION_START = 1'b0;
    localparam logic CFG_REGION_SIZE  = 1'b1;

    localparam logic [31:0] MIN_GRANULE = 32'd4;

    typedef struct packed {
        mode_t              mode;
        logic        [31:0] request_size;
        logic signed [31:0] alignment;
    } request_t;

    typedef struct packed {
        logic [31:0] block_address;
        logic        failed;
        logic [31:0] free_bytes;
        logic        consistent;
    } result_t;

endpackage

/* rtl/core/deba_alloc_calc.sv */
// Per-request allocation datapath: next pointer state and result fields.
module deba_alloc_calc
    import deba_pkg::*;
#(
    parameter int ADDR_WIDTH = 32
) (
    input  request_t                req,
    input  logic [ADDR_WIDTH-1:0]   region_start,
    input  logic [ADDR_WIDTH-1:0]   region_size,
    input  logic [ADDR_WIDTH-1:0]   head_pointer,
    input  logic [ADDR_WIDTH-1:0]   tail_pointer,
    input  logic [ADDR_WIDTH-1:0]   free_count,
    output logic [ADDR_WIDTH-1:0]   head_upd,
    output logic [ADDR_WIDTH-1:0]   tail_upd,
    output logic [ADDR_WIDTH-1:0]   free_upd,
    output result_t                 result
);

    // compare width: rounded size plus padding needs 34 bits
    localparam int CW = (ADDR_WIDTH > 34) ? ADDR_WIDTH : 34;
    localparam int XW = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;

    logic                  from_tail;
    logic [31:0]           size_min;
    logic [31:0]           mag;
    logic [31:0]           align_raw;
    logic [31:0]           align_min;
    logic [31:0]           align_mask;
    logic [33:0]           size_rnd;
    logic [ADDR_WIDTH-1:0] neg_head;
    logic [CW-1:0]         pad;
    logic [CW-1:0]         need_head;
    logic [CW-1:0]         free_c;
    logic [CW-1:0]         tail_c;
    logic [CW-1:0]         size_c;
    logic [CW-1:0]         mask_c;
    logic [CW-1:0]         tail_start;
    logic [CW-1:0]         need_tail;
    logic                  head_fit;
    logic                  tail_fit;
    logic [ADDR_WIDTH-1:0] region_end;
    logic [ADDR_WIDTH-1:0] acct_sum;
    logic [ADDR_WIDTH-1:0] addr_sel;
    logic [XW-1:0]         addr_x;
    logic [XW-1:0]         free_x;
    logic                  fail;
    logic                  ok;

    assign from_tail  = req.alignment[31];
    assign size_min   = (req.request_size < MIN_GRANULE) ? MIN_GRANULE : req.request_size;
    assign mag        = ~req.alignment + 32'd1;
    assign align_raw  = from_tail ? mag : req.alignment;
    assign align_min  = (align_raw < MIN_GRANULE) ? MIN_GRANULE : align_raw;
    assign align_mask = align_min - 32'd1;
    assign size_rnd   = ({2'b00, size_min} + {2'b00, align_mask}) & ~{2'b00, align_mask};

    assign free_c = CW'(free_count);
    assign size_c = CW'(size_rnd);
    assign mask_c = CW'(align_mask);

    // head side: pad up to the alignment, then the rounded size
    assign neg_head  = '0 - head_pointer;
    assign pad       = CW'(neg_head) & mask_c;
    assign need_head = size_c + pad;
    assign head_fit  = (need_head <= free_c);

    // tail side: step down by the size, then align down
    assign tail_c     = CW'(tail_pointer);
    assign tail_start = (tail_c - size_c) & ~mask_c;
    assign need_tail  = tail_c - tail_start;
    assign tail_fit   = (size_c <= tail_c) && (need_tail <= free_c);

    assign region_end = region_start + region_size;
    assign acct_sum   = free_count + (head_pointer - region_start) + (region_end - tail_pointer);

    always_comb begin
        head_upd = head_pointer;
        tail_upd = tail_pointer;
        free_upd = free_count;
        addr_sel = '0;
        fail     = 1'b0;
        ok       = 1'b0;
        case (req.mode)
            MODE_ALLOC: begin
                if (!from_tail) begin
                    if (head_fit) begin
                        addr_sel = head_pointer + pad[ADDR_WIDTH-1:0];
                        head_upd = head_pointer + need_head[ADDR_WIDTH-1:0];
                        free_upd = free_count - need_head[ADDR_WIDTH-1:0];
                    end else begin
                        fail = 1'b1;
                    end
                end else begin
                    if (tail_fit) begin
                        addr_sel = tail_start[ADDR_WIDTH-1:0];
                        tail_upd = tail_start[ADDR_WIDTH-1:0];
                        free_upd = free_count - need_tail[ADDR_WIDTH-1:0];
                    end else begin
                        fail = 1'b1;
                    end
                end
            end
            MODE_FREE_ALL: begin
                free_upd = region_size;
                head_upd = region_start;
                tail_upd = region_end;
            end
            MODE_FREE_TAIL: begin
                free_upd = free_count + (region_end - tail_pointer);
                tail_upd = region_end;
            end
            MODE_CHECK: begin
                ok = (acct_sum == region_size);
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign addr_x = XW'(addr_sel);
    assign free_x = XW'(free_upd);

    assign result.block_address = addr_x[31:0];
    assign result.failed        = fail;
    assign result.free_bytes    = free_x[31:0];
    assign result.consistent    = ok;

endmodule

/* rtl/core/double_ended_bump_allocator.sv */
// Top level of the double-ended bump allocator: channels, config and state registers.
//
// Usage:
//   Requests arrive on s_valid/s_ready/s_request (mode, size, signed alignment);
//   one result per request leaves on m_valid/m_ready/m_result.
//   A non-negative alignment allocates upward from the head, a negative one
//   downward from the tail. Config registers (0 region start, 1 region size)
//   are written through cfg_we/cfg_index/cfg_data; the user must do so only while
//   no request is in flight (not enforced by the block); issue a free-all request
//   afterwards to set up the pointers. An accepted request waits in the input
//   register, where a stall on m_ready can hold it, until its result is registered.
//   Throughput: one request per cycle while m_ready is high, limited by the single
//   calculation stage between the input register and the result register.
//   Reset (aresetn low, synchronous) clears both stages, the config registers
//   and the head, tail and free-count registers to zero.
//   When m_ready is low the result holds, the input register fills once, and
//   s_ready then drops until the result is taken.
module double_ended_bump_allocator
    import deba_pkg::*;
#(
    parameter int ADDR_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  request_t    s_request,
    output logic        m_valid,
    input  logic        m_ready,
    output result_t     m_result
);

    logic                  in_valid_reg;
    request_t              in_req_reg;
    logic                  out_valid_reg;
    result_t               out_res_reg;
    logic [ADDR_WIDTH-1:0] region_start_reg;
    logic [ADDR_WIDTH-1:0] region_size_reg;
    logic [ADDR_WIDTH-1:0] head_pointer_reg;
    logic [ADDR_WIDTH-1:0] tail_pointer_reg;
    logic [ADDR_WIDTH-1:0] free_count_reg;
    logic [ADDR_WIDTH-1:0] head_pointer_next;
    logic [ADDR_WIDTH-1:0] tail_pointer_next;
    logic [ADDR_WIDTH-1:0] free_count_next;
    result_t               out_res_next;
    logic                  advance;
    logic                  take;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take    = s_valid && s_ready;

    deba_alloc_calc #(
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_calc (
        .req          (in_req_reg),
        .region_start (region_start_reg),
        .region_size  (region_size_reg),
        .head_pointer (head_pointer_reg),
        .tail_pointer (tail_pointer_reg),
        .free_count   (free_count_reg),
        .head_upd     (head_pointer_next),
        .tail_upd     (tail_pointer_next),
        .free_upd     (free_count_next),
        .result       (out_res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            region_start_reg <= '0;
            region_size_reg  <= '0;
            head_pointer_reg <= '0;
            tail_pointer_reg <= '0;
            free_count_reg   <= '0;
        end else begin
            if (take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg    <= 1'b1;
                head_pointer_reg <= head_pointer_next;
                tail_pointer_reg <= tail_pointer_next;
                free_count_reg   <= free_count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_REGION_START: region_start_reg <= ADDR_WIDTH'(cfg_data);
                    CFG_REGION_SIZE:  region_size_reg  <= ADDR_WIDTH'(cfg_data);
                    default:          region_size_reg  <= region_size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_req_reg <= s_request;
        end
        if (advance) begin
            out_res_reg <= out_res_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_res_reg;

endmodule
